[design/cti_pkg.sv]
// Package with shared types and constants for the curve table interpolation core.
package cti_pkg;

  localparam int TableSize = 16;
  localparam int IdxW = $clog2(TableSize);

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_SET    = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EQUAL    = 2'd1,
    ST_SATURATE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD1,
    S_RD2,
    S_MUL,
    S_DIV,
    S_SUM,
    S_SETWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

[design/cti_divider.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
module cti_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [32:0]   divisor,
  output cti_pkg::div_ctl_t ctl,
  output logic [63:0]   quotient
);

  logic [63:0] q_r;
  logic [33:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] div_r;
  logic [33:0] trial;
  logic [34:0] diff;

  assign trial = {rem_r[32:0], q_r[63]};
  assign diff  = {1'b0, trial} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        q_r    <= dividend;
        rem_r  <= 34'd0;
        div_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[34]) begin
          rem_r <= diff[33:0];
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quotient  = q_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  assert property (p_done_after_busy) else $error("divider done without busy");

  property p_no_done_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  assert property (p_no_done_busy) else $error("divider done while busy");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r;
  endproperty
  assert property (p_start_busy) else $error("divider did not start");

endmodule

[design/cti_table_mem.sv]
// Key and value table memories with registered read data.
module cti_table_mem (
  input  logic                      clk,
  input  logic                      key_we,
  input  logic                      val_we,
  input  logic [cti_pkg::IdxW-1:0]  waddr,
  input  logic [31:0]               wkey,
  input  logic [31:0]               wval,
  input  logic [cti_pkg::IdxW-1:0]  raddr,
  output logic [31:0]               rkey,
  output logic [31:0]               rval
);

  logic [31:0] key_mem [cti_pkg::TableSize];
  logic [31:0] val_mem [cti_pkg::TableSize];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (val_we) begin
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

[design/curve_table_interpolation_core.sv]
// Top level of the curve table interpolation core: sequencer, memories and divider.
//
//  channel | ports                                          | handshake
//  in      | in_kind in_entry_index in_entry_key ...        | start & !busy
//  out     | out_result_value out_found_index ...           | done strobe, one cycle
//
// A load writes both tables on acceptance; a set or a lookup first searches: four probe
// reads and a read of the found entry. A set then writes, an end-point lookup stops, and
// an interpolating lookup adds two neighbour reads, a multiply, a divide step around a
// 64-bit bit-serial divide, a sum and the done state. The divider sets the lookup time.
// Reset clears only control state; tables are undefined until loaded.
// The receiver cannot stall: results are strobed with done.
module curve_table_interpolation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic signed [31:0] in_entry_key,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_query_key,
  output logic        done,
  output logic signed [31:0] out_result_value,
  output logic [3:0]  out_found_index,
  output logic        out_below_first,
  output logic [1:0]  out_status
);

  localparam int IW = cti_pkg::IdxW;

  cti_pkg::state_t state_r, state_nxt;
  cti_pkg::kind_t  kind_r;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW:0]     bit_r, bit_nxt;
  logic [IW:0]     probe;
  logic signed [31:0] q_r, eval_r;
  logic signed [31:0] x1_r, y1_r;
  logic [32:0]     dy_r, dq_r, dx_r;
  logic            neg_r, bel_r;
  logic [63:0]     prod_r;
  logic signed [31:0] res_r;
  logic [1:0]      stat_r;
  logic            done_r;

  logic            key_we, val_we;
  logic [IW-1:0]   waddr, raddr;
  logic [31:0]     wval;
  logic [31:0]     rkey, rval;
  logic            div_start;
  cti_pkg::div_ctl_t div_ctl;
  logic [63:0]     quo;

  logic signed [33:0] ddy, ddq, ddx;
  logic [63:0]     qt;
  logic signed [34:0] sum;

  assign probe = {1'b0, idx_r} | bit_r;
  assign ddy = 34'(signed'(rval)) - 34'(y1_r);
  assign ddq = 34'(q_r) - 34'(x1_r);
  assign ddx = 34'(signed'(rkey)) - 34'(x1_r);
  assign qt  = (quo > 64'h2_0000_0000) ? 64'h2_0000_0000 : quo;
  assign sum = 35'(y1_r) + (neg_r ? -35'(signed'({1'b0, qt[33:0]}))
                                  : 35'(signed'({1'b0, qt[33:0]})));

  cti_table_mem u_mem (
    .clk(clk), .key_we(key_we), .val_we(val_we), .waddr(waddr),
    .wkey(in_entry_key), .wval(wval), .raddr(raddr), .rkey(rkey), .rval(rval)
  );

  cti_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r + {32'd0, dx_r[32:1]}),
    .divisor(dx_r), .ctl(div_ctl), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cti_pkg::S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_nxt == cti_pkg::S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    bit_r <= bit_nxt;
    unique case (state_r)
      cti_pkg::S_IDLE: begin
        kind_r <= cti_pkg::kind_t'(in_kind);
        q_r    <= in_query_key;
        eval_r <= in_entry_value;
        res_r  <= 32'sd0;
        stat_r <= cti_pkg::ST_OK;
        bel_r  <= 1'b0;
      end
      cti_pkg::S_SRCH_CMP: begin
        if (bit_r == '0) begin
          bel_r <= (idx_r == '0) && (signed'(rkey) > q_r);
          x1_r  <= rkey;
          y1_r  <= rval;
        end
      end
      cti_pkg::S_RD2: begin
        dy_r  <= ddy[33] ? 33'(-ddy) : ddy[32:0];
        dq_r  <= ddq[33] ? 33'(-ddq) : ddq[32:0];
        dx_r  <= ddx[33] ? 33'(-ddx) : ddx[32:0];
        neg_r <= (ddy[33] ^ ddq[33] ^ ddx[33]) && (ddy != 0) && (ddq != 0);
        if (ddx == 0) begin
          stat_r <= cti_pkg::ST_EQUAL;
        end
      end
      cti_pkg::S_MUL: begin
        prod_r <= {31'd0, dy_r} * {31'd0, dq_r};
      end
      cti_pkg::S_SUM: begin
        if (sum > 35'sh7FFF_FFFF) begin
          res_r <= 32'h7FFF_FFFF;  stat_r <= cti_pkg::ST_SATURATE;
        end else if (sum < -35'sh8000_0000) begin
          res_r <= 32'h8000_0000;  stat_r <= cti_pkg::ST_SATURATE;
        end else begin
          res_r <= sum[31:0];
        end
      end
      cti_pkg::S_RD1: begin
        if (bel_r || idx_r == IW'(cti_pkg::TableSize - 1)) begin
          res_r <= y1_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    key_we    = 1'b0;
    val_we    = 1'b0;
    waddr     = in_entry_index[IW-1:0];
    wval      = in_entry_value;
    raddr     = probe[IW-1:0];
    div_start = 1'b0;
    unique case (state_r)
      cti_pkg::S_IDLE: begin
        idx_nxt = '0;
        bit_nxt = (IW+1)'(cti_pkg::TableSize / 2);
        if (start) begin
          unique case (cti_pkg::kind_t'(in_kind))
            cti_pkg::KIND_LOAD: begin
              key_we = 1'b1;
              val_we = 1'b1;
              state_nxt = cti_pkg::S_DONE;
            end
            cti_pkg::KIND_LOOKUP, cti_pkg::KIND_SET: state_nxt = cti_pkg::S_SRCH_RD;
            default: state_nxt = cti_pkg::S_DONE;
          endcase
        end
      end
      cti_pkg::S_SRCH_RD: begin
        raddr = (bit_r == '0) ? idx_r : probe[IW-1:0];
        state_nxt = cti_pkg::S_SRCH_CMP;
      end
      cti_pkg::S_SRCH_CMP: begin
        if (bit_r == '0) begin
          state_nxt = (kind_r == cti_pkg::KIND_SET) ? cti_pkg::S_SETWR : cti_pkg::S_RD1;
        end else begin
          if (signed'(rkey) <= q_r) begin
            idx_nxt = probe[IW-1:0];
          end
          bit_nxt   = bit_r >> 1;
          state_nxt = cti_pkg::S_SRCH_RD;
        end
      end
      cti_pkg::S_RD1: begin
        raddr = idx_r + IW'(1);
        if (bel_r || idx_r == IW'(cti_pkg::TableSize - 1)) begin
          state_nxt = cti_pkg::S_DONE;
        end else begin
          state_nxt = cti_pkg::S_RD2;
        end
      end
      cti_pkg::S_RD2: begin
        state_nxt = (ddx == 0) ? cti_pkg::S_DONE : cti_pkg::S_MUL;
      end
      cti_pkg::S_MUL: begin
        state_nxt = cti_pkg::S_DIV;
      end
      cti_pkg::S_DIV: begin
        if (!div_ctl.busy && !div_ctl.done) begin
          div_start = 1'b1;
        end
        if (div_ctl.done) begin
          state_nxt = cti_pkg::S_SUM;
        end
      end
      cti_pkg::S_SUM: begin
        state_nxt = cti_pkg::S_DONE;
      end
      cti_pkg::S_SETWR: begin
        val_we    = 1'b1;
        waddr     = idx_r;
        wval      = eval_r;
        state_nxt = cti_pkg::S_DONE;
      end
      cti_pkg::S_DONE: begin
        state_nxt = cti_pkg::S_IDLE;
      end
      default: state_nxt = cti_pkg::S_IDLE;
    endcase
  end

  assign busy             = (state_r != cti_pkg::S_IDLE);
  assign done             = done_r;
  assign out_result_value = (kind_r == cti_pkg::KIND_LOOKUP) ? res_r : 32'sd0;
  assign out_found_index  = (kind_r == cti_pkg::KIND_LOOKUP || kind_r == cti_pkg::KIND_SET)
                            ? 4'(idx_r) : 4'd0;
  assign out_below_first  = (kind_r == cti_pkg::KIND_LOOKUP || kind_r == cti_pkg::KIND_SET)
                            ? bel_r : 1'b0;
  assign out_status       = (kind_r == cti_pkg::KIND_LOOKUP) ? stat_r : 2'd0;

  property p_done_one_cycle;
    @(posedge clk) disable iff (!rst_n) done |=> !done;
  endproperty
  assert property (p_done_one_cycle) else $error("done held longer than one cycle");

  property p_idle_after_done;
    @(posedge clk) disable iff (!rst_n) done |=> !busy;
  endproperty
  assert property (p_idle_after_done) else $error("busy after result shown");

  property p_div_only_in_div;
    @(posedge clk) disable iff (!rst_n) div_start |-> state_r == cti_pkg::S_DIV;
  endproperty
  assert property (p_div_only_in_div) else $error("divider started outside divide step");

endmodule
